// ===== design/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/modexp_pkg.sv =====
// Constants, types and modular step functions for the modular exponentiation block.
package modexp_pkg;

    localparam int WIDTH   = 32;
    localparam int FIELD_W = 32;
    localparam int CNT_W   = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    typedef logic [WIDTH-1:0] operand_t;
    typedef logic [CNT_W-1:0] bit_cnt_t;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_REDUCE = 2'd1;
    localparam logic [1:0] ST_MULT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // 2*r mod m, r < m; modulus zero wraps at the operand width
    function automatic operand_t mod_double(operand_t r, operand_t m);
        logic [WIDTH:0] t;
        t = {r, 1'b0};
        if (m != '0 && t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        return t[WIDTH-1:0];
    endfunction

    // x + a mod m, x < m, a <= m; modulus zero wraps at the operand width
    function automatic operand_t mod_add(operand_t x, operand_t a, operand_t m);
        logic [WIDTH:0] t;
        t = {1'b0, x} + {1'b0, a};
        if (m != '0 && t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        return t[WIDTH-1:0];
    endfunction

endpackage

// ===== design/modular_exponentiation.sv =====
// Top level: right-to-left binary modular exponentiation with bit-serial multipliers.
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  input   | s_valid s_ready s_base_value s_exponent    | in
//  result  | m_valid m_ready m_power_result             | out
//  config  | cfg_valid cfg_ready cfg_wdata (modulus)    | in
//
// One word in flight. The base is reduced first, then each exponent bit up to the highest
// set one is worked by a product and a square that run side by side; each multiplier bit
// is a doubling phase then an add phase, and a finish state hands the result on.
// Synchronous active-low reset, modulus 1.
// A new word is taken while the previous result waits in the output register.
`include "assert_macros.svh"

module modular_exponentiation
    import modexp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FIELD_W-1:0] s_base_value,
    input  logic [FIELD_W-1:0] s_exponent,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FIELD_W-1:0] m_power_result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [FIELD_W-1:0] cfg_wdata
);

    logic [1:0] state_reg, state_next;
    logic       phase_reg, phase_next;
    bit_cnt_t   cnt_reg, cnt_next;
    operand_t   exp_reg, exp_next;
    operand_t   base_reg, base_next;
    operand_t   acc_reg, acc_next;
    operand_t   mula_reg, mula_next;
    operand_t   mulb_reg, mulb_next;
    operand_t   racc_reg, racc_next;
    operand_t   rsq_reg, rsq_next;
    operand_t   modulus_reg, modulus_next;
    operand_t   out_reg, out_next;
    logic       out_valid_reg, out_valid_next;

    operand_t   dbl_acc, dbl_sq, add_acc, add_sq;
    operand_t   addend_acc, addend_sq;
    operand_t   exp_shift;

    assign s_ready        = (state_reg == ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign m_valid        = out_valid_reg;
    assign m_power_result = FIELD_W'(out_reg);

    always_comb begin
        addend_acc = mula_reg[WIDTH-1] ? base_reg : '0;
        if (state_reg == ST_REDUCE) begin
            addend_sq = mulb_reg[WIDTH-1] ? operand_t'(1) : '0;
        end else begin
            addend_sq = mulb_reg[WIDTH-1] ? base_reg : '0;
        end
        dbl_acc   = mod_double(racc_reg, modulus_reg);
        dbl_sq    = mod_double(rsq_reg, modulus_reg);
        add_acc   = mod_add(racc_reg, addend_acc, modulus_reg);
        add_sq    = mod_add(rsq_reg, addend_sq, modulus_reg);
        exp_shift = exp_reg >> 1;
    end

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        exp_next       = exp_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        mula_next      = mula_reg;
        mulb_next      = mulb_reg;
        racc_next      = racc_reg;
        rsq_next       = rsq_reg;
        modulus_next   = modulus_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (cfg_valid && cfg_ready) begin
            modulus_next = cfg_wdata[WIDTH-1:0];
        end
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    exp_next   = s_exponent[WIDTH-1:0];
                    mulb_next  = s_base_value[WIDTH-1:0];
                    mula_next  = '0;
                    racc_next  = '0;
                    rsq_next   = '0;
                    acc_next   = operand_t'(1);
                    cnt_next   = bit_cnt_t'(WIDTH - 1);
                    phase_next = 1'b0;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                phase_next = ~phase_reg;
                if (!phase_reg) begin
                    rsq_next = dbl_sq;
                end else begin
                    rsq_next  = add_sq;
                    mulb_next = mulb_reg << 1;
                    cnt_next  = cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        base_next = add_sq;
                        if (exp_reg == '0) begin
                            state_next = ST_FINISH;
                        end else begin
                            mula_next  = acc_reg;
                            mulb_next  = add_sq;
                            racc_next  = '0;
                            rsq_next   = '0;
                            cnt_next   = bit_cnt_t'(WIDTH - 1);
                            state_next = ST_MULT;
                        end
                    end
                end
            end
            ST_MULT: begin
                phase_next = ~phase_reg;
                if (!phase_reg) begin
                    racc_next = dbl_acc;
                    rsq_next  = dbl_sq;
                end else begin
                    racc_next = add_acc;
                    rsq_next  = add_sq;
                    mula_next = mula_reg << 1;
                    mulb_next = mulb_reg << 1;
                    cnt_next  = cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        if (exp_reg[0]) begin
                            acc_next = add_acc;
                        end
                        base_next = add_sq;
                        exp_next  = exp_shift;
                        if (exp_shift == '0) begin
                            state_next = ST_FINISH;
                        end else begin
                            mula_next = exp_reg[0] ? add_acc : acc_reg;
                            mulb_next = add_sq;
                            racc_next = '0;
                            rsq_next  = '0;
                            cnt_next  = bit_cnt_t'(WIDTH - 1);
                        end
                    end
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    out_next       = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            cnt_reg       <= '0;
            modulus_reg   <= operand_t'(1);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            modulus_reg   <= modulus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        exp_reg  <= exp_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
        mula_reg <= mula_next;
        mulb_reg <= mulb_next;
        racc_reg <= racc_next;
        rsq_reg  <= rsq_next;
        out_reg  <= out_next;
    end

    `ASSERT_NEXT(a_start, s_valid && s_ready, state_reg == ST_REDUCE,
        "accepted word did not start base reduction")
    `ASSERT_SAME(a_residue, state_reg == ST_MULT && modulus_reg != '0,
        racc_reg < modulus_reg && rsq_reg < modulus_reg && base_reg < modulus_reg,
        "partial product left the residue range")
    `ASSERT_NEXT(a_finish_hold, state_reg == ST_FINISH && out_valid_reg && !m_ready,
        state_reg == ST_FINISH && m_valid,
        "result dropped while output register was busy")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the modular exponentiation block.
module testbench;
    import modexp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_NS = 12_000_000;
    localparam int TAIL_CYCLES = 2200;
    localparam int RANDOM_PER_PHASE = 39;

    typedef struct packed {
        logic [FIELD_W-1:0] base_value;
        logic [FIELD_W-1:0] exponent;
    } exp_word_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [FIELD_W-1:0] s_base_value = '0;
    logic [FIELD_W-1:0] s_exponent = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [FIELD_W-1:0] m_power_result;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [FIELD_W-1:0] cfg_wdata = '0;

    exp_word_t          pending_words[$];
    logic [FIELD_W-1:0] expected_powers[$];
    logic [FIELD_W-1:0] modulus_shadow = 1;
    logic               in_taken = 1'b0;
    logic               out_taken = 1'b0;
    logic               idle_on = 1'b1;
    int                 gap_left = 0;
    int                 stall_left = 0;
    int                 errors = 0;
    int                 results_seen = 0;
    int                 words_sent = 0;
    int                 modulus_writes = 0;

    modular_exponentiation i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_base_value   (s_base_value),
        .s_exponent     (s_exponent),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_power_result (m_power_result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_wdata      (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic logic [63:0] mod_reduce(logic [63:0] v, logic [63:0] m);
        logic [63:0] mask;
        mask = (64'd1 << WIDTH) - 64'd1;
        if (m == 0) begin
            return v & mask;
        end
        return v % m;
    endfunction

    // right-to-left square-and-multiply, exponent zero gives 1 unreduced
    function automatic logic [FIELD_W-1:0] mod_power(logic [FIELD_W-1:0] base_in,
                                                     logic [FIELD_W-1:0] exp_in,
                                                     logic [FIELD_W-1:0] mod_in);
        logic [63:0] mask;
        logic [63:0] m;
        logic [63:0] b;
        logic [63:0] e;
        logic [63:0] acc;
        mask = (64'd1 << WIDTH) - 64'd1;
        m = {32'd0, mod_in} & mask;
        b = mod_reduce({32'd0, base_in} & mask, m);
        e = {32'd0, exp_in} & mask;
        acc = 64'd1;
        for (int i = 0; i < WIDTH; i++) begin
            if (e == 0) begin
                break;
            end
            if (e[0]) begin
                acc = mod_reduce(acc * b, m);
            end
            e = e >> 1;
            b = mod_reduce(b * b, m);
        end
        return acc[FIELD_W-1:0];
    endfunction

    always @(negedge aclk) begin
        logic next_valid;
        exp_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            next_valid = s_valid && !in_taken;
            if (!next_valid) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_words.size() != 0) begin
                    w = pending_words.pop_front();
                    s_base_value <= w.base_value;
                    s_exponent <= w.exponent;
                    next_valid = 1'b1;
                    gap_left <= idle_on ? $urandom_range(0, 14) : 0;
                end
            end
            s_valid <= next_valid;
        end
    end

    always @(negedge aclk) begin
        int w;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (out_taken) begin
            w = idle_on ? $urandom_range(0, 14) : 0;
            m_ready <= (w == 0);
            stall_left <= (w == 0) ? 0 : w - 1;
        end else if (!m_ready) begin
            if (stall_left == 0) begin
                m_ready <= 1'b1;
            end else begin
                stall_left <= stall_left - 1;
            end
        end
    end

    always @(posedge aclk) begin
        logic [FIELD_W-1:0] want;
        if (!aresetn) begin
            in_taken <= 1'b0;
            out_taken <= 1'b0;
            modulus_shadow <= 1;
        end else begin
            in_taken <= s_valid && s_ready;
            out_taken <= m_valid && m_ready;
            if (cfg_valid && cfg_ready) begin
                modulus_shadow <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                expected_powers.push_back(mod_power(s_base_value, s_exponent, modulus_shadow));
                words_sent++;
            end
            if (m_valid && m_ready) begin
                if (expected_powers.size() == 0) begin
                    $error("power_result: expected nothing, got %h", m_power_result);
                    errors++;
                end else begin
                    want = expected_powers.pop_front();
                    results_seen++;
                    if (m_power_result !== want) begin
                        $error("power_result: expected %h, got %h", want, m_power_result);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic queue_word(logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] e);
        exp_word_t w;
        w.base_value = b;
        w.exponent = e;
        pending_words.push_back(w);
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || s_valid || expected_powers.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_modulus(logic [FIELD_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        modulus_writes++;
    endtask

    function automatic exp_word_t random_word(logic [FIELD_W-1:0] m);
        exp_word_t w;
        int pick;
        case ($urandom_range(0, 5))
            0: w.base_value = $urandom;
            1: w.base_value = $urandom_range(0, 15);
            2: w.base_value = m - $urandom_range(0, 3);
            3: w.base_value = m + $urandom_range(0, 3);
            4: w.base_value = {16'($urandom_range(0, 65535)), 16'h0} | $urandom_range(0, 65535);
            default: w.base_value = 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
        // mostly short exponents keep the run short; some span all bits
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            w.exponent = '0;
        end else if (pick <= 11) begin
            w.exponent = $urandom & 32'h0000_00FF;
        end else if (pick <= 16) begin
            w.exponent = $urandom & 32'h0000_FFFF;
        end else begin
            w.exponent = $urandom;
        end
        return w;
    endfunction

    initial begin
        logic [FIELD_W-1:0] moduli[7];
        exp_word_t w;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset modulus of one
        queue_word(32'd0, 32'd0);
        queue_word(32'd5, 32'd0);
        queue_word(32'hFFFF_FFFF, 32'd1);
        queue_word(32'd7, 32'hFFFF_FFFF);
        drain();

        write_modulus(32'hFFFF_FFFF);
        queue_word(32'd0, 32'd0);
        queue_word(32'd0, 32'd5);
        queue_word(32'hFFFF_FFFF, 32'd3);
        queue_word(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        queue_word(32'd2, 32'd31);
        queue_word(32'd2, 32'd32);
        queue_word(32'd3, 32'hFFFF_FFFF);
        queue_word(32'h8000_0000, 32'd2);
        queue_word(32'd1, 32'hFFFF_FFFF);
        drain();

        // largest 32-bit prime
        write_modulus(32'hFFFF_FFFB);
        queue_word(32'hFFFF_FFFA, 32'd2);
        queue_word(32'h1234_5678, 32'hFFFF_FFFA);
        queue_word(32'hFFFF_FFFF, 32'h8000_0001);
        queue_word(32'hDEAD_BEEF, 32'hFFFF_FFFF);
        drain();

        moduli[0] = 32'd2;
        moduli[1] = 32'hFFFF_FFFF;
        moduli[2] = $urandom | 32'd1;
        moduli[3] = 32'h8000_0000;
        moduli[4] = $urandom_range(3, 1000);
        moduli[5] = 32'd1;
        moduli[6] = $urandom | 32'h8000_0000;
        for (int p = 0; p < 7; p++) begin
            write_modulus(moduli[p]);
            idle_on = (p % 3) != 1;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                w = random_word(moduli[p]);
                pending_words.push_back(w);
            end
            drain();
        end
        idle_on = 1'b1;

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Sent %0d words over %0d modulus writes; %0d results checked, %0d errors.",
                 words_sent, modulus_writes, results_seen, errors);
        if (errors == 0 && expected_powers.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #LIMIT_NS;
        $display("TEST FAILED");
        $finish;
    end

endmodule
